// ----- rtl/hns_pkg.sv -----
// shared types, constants and helpers of the heightmap normal stream
// no dependencies; imported by every module of the block but hns_ram
package hns_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int QUEUE_DEPTH    = 4;

	localparam int HEIGHT_W   = 8;
	localparam int COORD_W    = 10;
	localparam int NX_W       = 11;
	localparam int NY_W       = 7;
	localparam int CFG_W      = 11;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(512);

	// register index codes, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// fixed y components of the scaled cross product
	localparam logic signed [NY_W-1:0] NY_ZERO  = 7'sd0;
	localparam logic signed [NY_W-1:0] NY_POS10 = 7'sd10;
	localparam logic signed [NY_W-1:0] NY_NEG10 = -7'sd10;
	localparam logic signed [NY_W-1:0] NY_NEG20 = -7'sd20;

	// one pixel worth of work for the back end
	typedef struct packed {
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic                emit_a;   // vertex one row up
		logic                emit_b;   // vertex one column left, last row
		logic                emit_c;   // vertex itself, last pixel of frame
		logic                top_row;  // vertex one row up sits on the first row
		logic                last_col;
		logic [HEIGHT_W-1:0] s;        // this sample
		logic [HEIGHT_W-1:0] sp;       // sample one column left
		logic [HEIGHT_W-1:0] p0;       // previous row, this column
		logic [HEIGHT_W-1:0] pn;       // previous row, next column
		logic [HEIGHT_W-1:0] q;        // previous row, column left
		logic [HEIGHT_W-1:0] t0;       // two rows back, this column
	} rec_t;

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
		int vi;
		vi = int'(v);
		if (vi < 2)
			clamp_dim = 2;
		else if (vi > maxv)
			clamp_dim = maxv;
		else
			clamp_dim = vi;
	endfunction

	function automatic logic signed [NX_W-1:0] ext_h(input logic [HEIGHT_W-1:0] h);
		ext_h = signed'({{(NX_W-HEIGHT_W){1'b0}}, h});
	endfunction

endpackage

// ----- rtl/hns_ram.sv -----
// generic ram: one write port, two read ports with registered data
// no dependencies
module hns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- rtl/hns_front.sv -----
// front end: position counters, three rotating line buffers, classification
// depends on hns_pkg and hns_ram
module hns_front import hns_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int QDEPTH     = QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [$clog2(MAX_WIDTH)-1:0]  last_col,
	input  logic [$clog2(MAX_HEIGHT)-1:0] last_row,
	input  logic                          push,
	output logic                          full,
	input  logic [HEIGHT_W-1:0]           height_sample,
	input  logic [$clog2(QDEPTH+1)-1:0]   q_level,
	output logic                          rec_valid,
	output rec_t                          rec
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(QDEPTH+1);

	localparam logic [1:0] BANK_0 = 2'd0;
	localparam logic [1:0] BANK_1 = 2'd1;
	localparam logic [1:0] BANK_2 = 2'd2;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    bank_q;

	logic                valid_s1;
	logic [HEIGHT_W-1:0] sample_s1;
	logic [COORD_W-1:0]  col_s1;
	logic [COORD_W-1:0]  row_s1;
	logic                emit_a_s1;
	logic                emit_b_s1;
	logic                emit_c_s1;
	logic                top_s1;
	logic                lastc_s1;
	logic [1:0]          bank_s1;

	logic [HEIGHT_W-1:0] prev_sample_q;
	logic [HEIGHT_W-1:0] prev_p0_q;

	logic [HEIGHT_W-1:0] rd_a [3];
	logic [HEIGHT_W-1:0] rd_b [3];
	logic [HEIGHT_W-1:0] p0, pn, t0;

	logic          accept;
	logic          end_of_row;
	logic          on_last_row;
	logic [LW:0]   level;

	// every accepted item is sure of a queue slot in the cycle after it is accepted
	assign level       = {1'b0, q_level} + {{LW{1'b0}}, valid_s1};
	assign full        = level >= (LW+1)'(QDEPTH);
	assign accept      = push & ~full;
	assign end_of_row  = col_q == last_col;
	assign on_last_row = row_q == last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= BANK_0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_of_row) begin
				col_q  <= '0;
				row_q  <= on_last_row ? '0 : row_q + 1'b1;
				bank_q <= (bank_q == BANK_2) ? BANK_0 : bank_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= height_sample;
			col_s1    <= COORD_W'(col_q);
			row_s1    <= COORD_W'(row_q);
			emit_a_s1 <= row_q != '0;
			emit_b_s1 <= on_last_row && (col_q != '0);
			emit_c_s1 <= on_last_row && end_of_row;
			top_s1    <= row_q == RW'(1);
			lastc_s1  <= end_of_row;
			bank_s1   <= bank_q;
		end
		if (valid_s1) begin
			prev_sample_q <= sample_s1;
			prev_p0_q     <= p0;
		end
	end

	// the current bank takes the sample, the other two are read at c and c+1
	for (genvar i = 0; i < 3; i++) begin : g_bank
		hns_ram #(
			.WIDTH (HEIGHT_W),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk     (clk),
			.we      (accept && (bank_q == 2'(i))),
			.waddr   (col_q),
			.wdata   (height_sample),
			.raddr_a (col_q),
			.raddr_b (col_q + 1'b1),
			.rdata_a (rd_a[i]),
			.rdata_b (rd_b[i])
		);
	end

	// previous row lives one bank behind the current one, two rows back two behind
	always_comb begin
		p0 = '0;
		pn = '0;
		t0 = '0;
		case (bank_s1)
			BANK_0: begin
				p0 = rd_a[2];
				pn = rd_b[2];
				t0 = rd_a[1];
			end
			BANK_1: begin
				p0 = rd_a[0];
				pn = rd_b[0];
				t0 = rd_a[2];
			end
			BANK_2: begin
				p0 = rd_a[1];
				pn = rd_b[1];
				t0 = rd_a[0];
			end
			default: begin
				p0 = '0;
				pn = '0;
				t0 = '0;
			end
		endcase
	end

	assign rec_valid    = valid_s1 & (emit_a_s1 | emit_b_s1 | emit_c_s1);
	assign rec.col      = col_s1;
	assign rec.row      = row_s1;
	assign rec.emit_a   = emit_a_s1;
	assign rec.emit_b   = emit_b_s1;
	assign rec.emit_c   = emit_c_s1;
	assign rec.top_row  = top_s1;
	assign rec.last_col = lastc_s1;
	assign rec.s        = sample_s1;
	assign rec.sp       = prev_sample_q;
	assign rec.p0       = p0;
	assign rec.pn       = pn;
	assign rec.q        = prev_p0_q;
	assign rec.t0       = t0;

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col) && (row_q <= last_row))
		else $error("position counter outside configured grid");

	a_queue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (q_level < LW'(QDEPTH)))
		else $error("front pushed into a full queue");

endmodule

// ----- rtl/hns_queue.sv -----
// short queue of per-pixel work records between front and back
// depends on hns_pkg
module hns_queue import hns_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rec_t                       din,
	input  logic                       pop,
	output rec_t                       dout,
	output logic                       valid,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [LW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout  = mem_q[rd_q];
	assign valid = count_q != '0;
	assign level = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- rtl/hns_back.sv -----
// back end: walks the vertices of a record, forms the scaled cross product
// depends on hns_pkg
module hns_back import hns_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rec_t                          head,
	input  logic                          head_valid,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [COORD_W-1:0]            vertex_col,
	output logic [COORD_W-1:0]            vertex_row,
	output logic signed [NX_W-1:0]        normal_x_times_ten,
	output logic signed [NY_W-1:0]        normal_y_times_ten,
	output logic signed [NX_W-1:0]        normal_z_times_ten,
	output logic                          last_of_run
);

	localparam logic [1:0] VX_A    = 2'd0;
	localparam logic [1:0] VX_B    = 2'd1;
	localparam logic [1:0] VX_C    = 2'd2;
	localparam logic [1:0] VX_NONE = 2'd3;

	logic [2:0] done_q;
	logic [2:0] rem;
	logic [2:0] selbit;
	logic [1:0] sel;
	logic       last_sel;
	logic       load;

	logic                        valid_q;
	logic [COORD_W-1:0]          ocol_q, orow_q;
	logic signed [NX_W-1:0]      nx_q, nz_q;
	logic signed [NY_W-1:0]      ny_q;
	logic                        last_q;

	logic [COORD_W-1:0]          col, row;
	logic signed [NX_W-1:0]      nx, nz, n1;
	logic signed [NY_W-1:0]      ny;
	logic signed [NX_W-1:0]      s, sp, p0, pn, q, t0;

	assign rem = {head.emit_c, head.emit_b, head.emit_a} & ~done_q;

	// oldest vertex first: one row up, then one column left, then the vertex itself
	always_comb begin
		sel    = VX_NONE;
		selbit = 3'b000;
		if (rem[0]) begin
			sel    = VX_A;
			selbit = 3'b001;
		end else if (rem[1]) begin
			sel    = VX_B;
			selbit = 3'b010;
		end else if (rem[2]) begin
			sel    = VX_C;
			selbit = 3'b100;
		end
	end

	assign last_sel = (rem & ~selbit) == 3'b000;
	assign load     = head_valid & (~valid_q | pop);
	assign q_pop    = load & last_sel;

	assign s  = ext_h(head.s);
	assign sp = ext_h(head.sp);
	assign p0 = ext_h(head.p0);
	assign pn = ext_h(head.pn);
	assign q  = ext_h(head.q);
	assign t0 = ext_h(head.t0);

	always_comb begin
		col = head.col;
		row = head.row;
		nx  = '0;
		nz  = '0;
		ny  = NY_ZERO;
		n1  = '0;
		case (sel)
			VX_A: begin
				row = head.row - 1'b1;
				if (head.top_row) begin
					// neighbours on the first row, last column looks left
					n1 = head.last_col ? q : pn;
					nx = n1 - p0;
					nz = head.last_col ? p0 - s : s - p0;
					ny = head.last_col ? NY_POS10 : NY_NEG10;
				end else begin
					// inner row, spans two rows in z
					n1 = head.last_col ? p0 : pn;
					nx = n1 + n1 - t0 - s;
					nz = head.last_col ? '0 : s - t0;
					ny = head.last_col ? NY_ZERO : NY_NEG20;
				end
			end
			VX_B: begin
				col = head.col - 1'b1;
				nx  = s - sp;
				nz  = sp - q;
				ny  = NY_NEG10;
			end
			VX_C: begin
				nx = s - sp;
				nz = s - p0;
				ny = NY_NEG10;
			end
			default: begin
				nx = '0;
				nz = '0;
				ny = NY_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 3'b000;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (pop)
				valid_q <= 1'b0;
			if (load)
				done_q <= last_sel ? 3'b000 : (done_q | selbit);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ocol_q <= col;
			orow_q <= row;
			nx_q   <= nx;
			ny_q   <= ny;
			nz_q   <= nz;
			last_q <= last_sel;
		end
	end

	assign empty              = ~valid_q;
	assign vertex_col         = ocol_q;
	assign vertex_row         = orow_q;
	assign normal_x_times_ten = nx_q;
	assign normal_y_times_ten = ny_q;
	assign normal_z_times_ten = nz_q;
	assign last_of_run        = last_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (rem != 3'b000))
		else $error("queue head with no vertex left");

	a_frame_end_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.emit_c) |-> (head.emit_a && head.emit_b))
		else $error("last pixel of frame without its other two vertices");

	a_ny_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (ny_q == NY_ZERO || ny_q == NY_POS10 || ny_q == NY_NEG10 ||
			ny_q == NY_NEG20))
		else $error("y component outside the grid spacing cases");

endmodule

// ----- rtl/heightmap_normal_stream.sv -----
// path: a sample goes through the front stage, the record queue and the output register
// throughput: one sample per cycle unless full, one normal out per cycle while pop is high, so
//   last-row samples (two normals past column 0, three on the final pixel) pace the input
// reset: arst_n clears counters, bank rotation, queue and output; sizes return to 512
// line buffers are not cleared: a frame only reads rows it has already written
// depends on hns_pkg, hns_front, hns_queue, hns_back, hns_ram
module heightmap_normal_stream import hns_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int QDEPTH     = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	// sample side
	input  logic                   push,
	output logic                   full,
	input  logic [HEIGHT_W-1:0]    height_sample,
	// result side
	output logic                   empty,
	input  logic                   pop,
	output logic [COORD_W-1:0]     vertex_col,
	output logic [COORD_W-1:0]     vertex_row,
	output logic signed [NX_W-1:0] normal_x_times_ten,
	output logic signed [NY_W-1:0] normal_y_times_ten,
	output logic signed [NX_W-1:0] normal_z_times_ten,
	output logic                   last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(QDEPTH+1);

	// clamped reset sizes, kept as last index
	localparam logic [CW-1:0] LAST_COL_RST = CW'(clamp_dim(CFG_DIM_RESET, MAX_WIDTH) - 1);
	localparam logic [RW-1:0] LAST_ROW_RST = RW'(clamp_dim(CFG_DIM_RESET, MAX_HEIGHT) - 1);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CW-1:0]    last_col_q;
	logic [RW-1:0]    last_row_q;

	logic             cfg_we;
	logic             cfg_idx;

	logic             rec_valid;
	rec_t             rec;
	rec_t             head;
	logic             head_valid;
	logic             q_pop;
	logic [LW-1:0]    q_level;

	// apb: zero wait states, register picked by the word address bit
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[2];

	// raw value kept for readback, clamped last index kept for the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= CFG_DIM_RESET;
			height_q   <= CFG_DIM_RESET;
			last_col_q <= LAST_COL_RST;
			last_row_q <= LAST_ROW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH: begin
					width_q    <= pwdata[CFG_W-1:0];
					last_col_q <= CW'(clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH) - 1);
				end
				REG_IMAGE_HEIGHT: begin
					height_q   <= pwdata[CFG_W-1:0];
					last_row_q <= RW'(clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT) - 1);
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_IMAGE_WIDTH:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, width_q};
			REG_IMAGE_HEIGHT: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, height_q};
			default:          prdata = '0;
		endcase
	end

	// any size write restarts the frame at the top left pixel
	hns_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.QDEPTH     (QDEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_we),
		.last_col      (last_col_q),
		.last_row      (last_row_q),
		.push          (push),
		.full          (full),
		.height_sample (height_sample),
		.q_level       (q_level),
		.rec_valid     (rec_valid),
		.rec           (rec)
	);

	// per-pixel records wait here while the back end spreads them over cycles
	hns_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_valid),
		.din    (rec),
		.pop    (q_pop),
		.dout   (head),
		.valid  (head_valid),
		.level  (q_level)
	);

	// one normal per cycle into the output register while pop is high or the register is empty
	hns_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.head_valid         (head_valid),
		.q_pop              (q_pop),
		.empty              (empty),
		.pop                (pop),
		.vertex_col         (vertex_col),
		.vertex_row         (vertex_row),
		.normal_x_times_ten (normal_x_times_ten),
		.normal_y_times_ten (normal_y_times_ten),
		.normal_z_times_ten (normal_z_times_ten),
		.last_of_run        (last_of_run)
	);

endmodule

// ----- bench/heightmap_normal_stream_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for heightmap_normal_stream: a directed table of small grids,
// then random frames over many grid settings; depends on hns_pkg and the block's rtl
module heightmap_normal_stream_test;
	import hns_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	// a sample reaches the ports through the front stage, the record queue and the
	// output register, so this covers the pipeline
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off, well past what the output queue can absorb
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASES        = 8;
	// vertices are placed at height/10, the block reports everything times ten
	localparam int HEIGHT_SCALE  = 10;
	localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
	localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

	// one normal as it leaves the block
	typedef struct packed {
		logic [COORD_W-1:0]     col;
		logic [COORD_W-1:0]     row;
		logic signed [NX_W-1:0] nx;
		logic signed [NY_W-1:0] ny;
		logic signed [NX_W-1:0] nz;
		logic                   last;
	} normal_t;

	// one row of the directed table: optional regrid, the sample, and typed normals
	// where they can be read straight off the geometry (typed = 0 means predicted)
	typedef struct packed {
		logic                retune;
		logic [31:0]         w_val;
		logic [31:0]         h_val;
		logic [HEIGHT_W-1:0] sample;
		logic [1:0]          typed;
		normal_t             t0;
		normal_t             t1;
		normal_t             t2;
	} dir_step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   push = 1'b0;
	logic                   full;
	logic [HEIGHT_W-1:0]    height_sample = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [COORD_W-1:0]     vertex_col;
	logic [COORD_W-1:0]     vertex_row;
	logic signed [NX_W-1:0] normal_x_times_ten;
	logic signed [NY_W-1:0] normal_y_times_ten;
	logic signed [NX_W-1:0] normal_z_times_ten;
	logic                   last_of_run;

	heightmap_normal_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.height_sample(height_sample),
		.empty(empty),
		.pop(pop),
		.vertex_col(vertex_col),
		.vertex_row(vertex_row),
		.normal_x_times_ten(normal_x_times_ten),
		.normal_y_times_ten(normal_y_times_ten),
		.normal_z_times_ten(normal_z_times_ten),
		.last_of_run(last_of_run)
	);

	always #CLK_HALF clk = ~clk;

	// predictor state: raw register contents, raster position, three line buffers
	logic [CFG_W-1:0]    width_reg = CFG_DIM_RESET;
	logic [CFG_W-1:0]    height_reg = CFG_DIM_RESET;
	int                  col_pos = 0;
	int                  row_pos = 0;
	logic [HEIGHT_W-1:0] line_now [DEF_MAX_WIDTH];
	logic [HEIGHT_W-1:0] line_up1 [DEF_MAX_WIDTH];
	logic [HEIGHT_W-1:0] line_up2 [DEF_MAX_WIDTH];

	normal_t   expected_normals[$];
	dir_step_t directed_steps[$];

	// sender pacing and receiver hold-off requests
	int burst_left = 0;
	bit steady_feed = 1'b0;
	int hold_asks = 0;
	int hold_done = 0;

	// run statistics
	int fail_count = 0;
	int samples_sent = 0;
	int normals_checked = 0;
	int grids_programmed = 0;
	int full_hits = 0;

	// random phases: raw width and height register values, samples per phase
	// out-of-range values check the clamp, upper pwdata bits must be dropped
	logic [31:0] phase_w [PHASES] = '{32'd0, 32'd4, 32'hABCD_0007, 32'd2,
		32'd16, 32'd5, 32'd9, 32'd2047};
	logic [31:0] phase_h [PHASES] = '{32'd5, 32'd1, 32'd4, 32'd2047,
		32'd3, 32'd6, 32'd2, 32'd2};
	// the last phase stays on the first row of an oversized width: no normals may leave
	int phase_items [PHASES] = '{30, 26, 60, 50, 80, 60, 70, 30};

	function automatic int used_dim(input logic [CFG_W-1:0] raw, input int maxv);
		if (int'(raw) < 2)
			return 2;
		if (int'(raw) > maxv)
			return maxv;
		return int'(raw);
	endfunction

	// height of grid point (col,row) while row cur is arriving
	function automatic int grid_height(input int col, input int row, input int cur);
		if (col >= DEF_MAX_WIDTH || row > cur)
			return 0;
		case (cur - row)
			0: return int'(line_now[col]);
			1: return int'(line_up1[col]);
			2: return int'(line_up2[col]);
			default: return 0;
		endcase
	endfunction

	// scaled cross product (n1 - n0) x (n2 - n0) for vertex (x,z)
	function automatic normal_t vertex_normal(input int x, input int z, input int w,
			input int h, input int cur);
		int c0, r0, c1, r1, c2, r2;
		int h0, ax, az, ah, bx, bz, bh, nx, ny, nz;
		normal_t n;
		c0 = x;
		r0 = (z != 0) ? z - 1 : z;
		c1 = x;
		r1 = z;
		c2 = x;
		r2 = z;
		if (x == w - 1) begin
			// last column looks left instead of right
			if (z == 0) begin
				c1 = x - 1;
				r2 = z + 1;
			end else if (z == h - 1) begin
				c2 = x - 1;
			end else begin
				r2 = z + 1;
			end
		end else begin
			c1 = x + 1;
			if (z != h - 1)
				r2 = z + 1;
		end
		h0 = grid_height(c0, r0, cur);
		ax = c1 - c0;
		az = r1 - r0;
		ah = grid_height(c1, r1, cur) - h0;
		bx = c2 - c0;
		bz = r2 - r0;
		bh = grid_height(c2, r2, cur) - h0;
		nx = ah * bz - az * bh;
		ny = HEIGHT_SCALE * (az * bx - ax * bz);
		nz = ax * bh - ah * bx;
		n.col  = x[COORD_W-1:0];
		n.row  = z[COORD_W-1:0];
		n.nx   = nx[NX_W-1:0];
		n.ny   = ny[NY_W-1:0];
		n.nz   = nz[NX_W-1:0];
		n.last = 1'b0;
		return n;
	endfunction

	function automatic normal_t mk_normal(input int col, input int row, input int nx,
			input int ny, input int nz, input bit last);
		normal_t n;
		n.col  = col[COORD_W-1:0];
		n.row  = row[COORD_W-1:0];
		n.nx   = nx[NX_W-1:0];
		n.ny   = ny[NY_W-1:0];
		n.nz   = nz[NX_W-1:0];
		n.last = last;
		return n;
	endfunction

	task automatic add_step(input logic retune, input logic [31:0] w_val,
			input logic [31:0] h_val, input logic [HEIGHT_W-1:0] sample,
			input logic [1:0] typed, input normal_t t0, input normal_t t1,
			input normal_t t2);
		dir_step_t st;
		st.retune = retune;
		st.w_val  = w_val;
		st.h_val  = h_val;
		st.sample = sample;
		st.typed  = typed;
		st.t0     = t0;
		st.t1     = t1;
		st.t2     = t2;
		directed_steps.push_back(st);
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// apb write: setup cycle, then access cycle; the register takes it at that edge
	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == WIDTH_ADDR)
			width_reg = data[CFG_W-1:0];
		else
			height_reg = data[CFG_W-1:0];
		// any register write restarts the frame
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
			input logic [CFG_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		compare_field(addr == WIDTH_ADDR ? "image_width" : "image_height",
			{21'b0, want}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_grid(input logic [31:0] w_val, input logic [31:0] h_val);
		reg_write(WIDTH_ADDR, w_val);
		reg_write(HEIGHT_ADDR, h_val);
		check_register(WIDTH_ADDR, width_reg);
		check_register(HEIGHT_ADDR, height_reg);
		grids_programmed++;
	endtask

	// stop feeding, let every expected normal out, then give the pipeline time
	// to finish first-row samples that leave nothing behind
	task automatic settle_block();
		@(negedge clk);
		push <= 1'b0;
		while (expected_normals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one sample, wait for it to be taken, then predict its normals
	task automatic feed_sample(input logic [HEIGHT_W-1:0] s, input logic [1:0] typed,
			input normal_t t0, input normal_t t1, input normal_t t2);
		normal_t run [3];
		int w, h, c, r, n, gap, i;
		// bursts of random length, with random gaps between them unless the feed is steady
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady_feed ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push          <= 1'b1;
		height_sample <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		samples_sent++;

		w = used_dim(width_reg, DEF_MAX_WIDTH);
		h = used_dim(height_reg, DEF_MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		n = 0;
		line_now[c] = s;
		// vertex one row up, then the last row's left neighbor, then the frame corner
		if (r >= 1) begin
			run[n] = vertex_normal(c, r - 1, w, h, r);
			n++;
		end
		if (r == h - 1) begin
			if (c >= 1) begin
				run[n] = vertex_normal(c - 1, r, w, h, r);
				n++;
			end
			if (c == w - 1) begin
				run[n] = vertex_normal(c, r, w, h, r);
				n++;
			end
		end
		if (n > 0)
			run[n-1].last = 1'b1;

		if (typed == 0) begin
			for (i = 0; i < n; i++)
				expected_normals.push_back(run[i]);
		end else begin
			expected_normals.push_back(t0);
			if (typed > 1)
				expected_normals.push_back(t1);
			if (typed > 2)
				expected_normals.push_back(t2);
		end

		// end of row: rotate the line buffers, wrap the frame after its last row
		if (c + 1 >= w) begin
			col_pos = 0;
			for (i = 0; i < w; i++) begin
				line_up2[i] = line_up1[i];
				line_up1[i] = line_now[i];
			end
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// receiver: stall patterns of its own, plus long hold-offs on request
	initial begin : receiver
		logic [7:0] pattern;
		int pattern_left, bit_idx, held;
		pattern = 8'hFF;
		pattern_left = 0;
		bit_idx = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_done != hold_asks) begin
				pop <= 1'b0;
				held++;
				if (held == HOLD_CYCLES) begin
					held = 0;
					hold_done++;
				end
			end else begin
				if (pattern_left == 0) begin
					// now and then a stretch that never stalls
					if ($urandom_range(0, 3) == 0)
						pattern = 8'hFF;
					else
						pattern = 8'($urandom) | 8'h01;
					pattern_left = $urandom_range(16, 64);
				end
				pop <= pattern[bit_idx];
				bit_idx = (bit_idx + 1) % 8;
				pattern_left--;
			end
		end
	end

	// result side: every accepted normal against the oldest expectation
	always @(posedge clk) begin : normal_check
		normal_t want;
		if (arst_n && push && full)
			full_hits++;
		if (arst_n && pop && !empty) begin
			if (expected_normals.size() == 0) begin
				$error("normal for col %0d row %0d arrived with none expected",
					vertex_col, vertex_row);
				fail_count++;
			end else begin
				want = expected_normals.pop_front();
				compare_field("vertex_col", want.col, vertex_col);
				compare_field("vertex_row", want.row, vertex_row);
				compare_field("normal_x_times_ten", $signed(want.nx), normal_x_times_ten);
				compare_field("normal_y_times_ten", $signed(want.ny), normal_y_times_ten);
				compare_field("normal_z_times_ten", $signed(want.nz), normal_z_times_ten);
				compare_field("last_of_run", want.last, last_of_run);
				normals_checked++;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("cycle limit of %0d reached, %0d normals still expected",
			CYCLE_LIMIT, expected_normals.size());
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int i, ph, k;
		logic [HEIGHT_W-1:0] s;
		dir_step_t st;

		// flat 2x2 frame: heights cancel, only the grid geometry is left
		add_step(1'b1, 32'd2, 32'd2, 8'h00, 2'd0, '0, '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'h00, 2'd0, '0, '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'h00, 2'd1,
			mk_normal(0, 0, 0, NY_NEG10, 0, 1'b1), '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'h00, 2'd3,
			mk_normal(1, 0, 0, NY_POS10, 0, 1'b0),
			mk_normal(0, 1, 0, NY_NEG10, 0, 1'b0),
			mk_normal(1, 1, 0, NY_NEG10, 0, 1'b1));
		// two more frames after the wrap, extremes in opposite corners
		for (i = 0; i < 8; i++)
			add_step(1'b0, 32'd0, 32'd0, ((i ^ (i >> 1) ^ (i >> 2)) & 1) ? 8'hFF : 8'h00,
				2'd0, '0, '0, '0);
		// 3x3 checkerboard: one inner row and an inner last column
		for (i = 0; i < 9; i++)
			add_step(i == 0, 32'd3, 32'd3, (i % 2) ? 8'hFF : 8'h00, 2'd0, '0, '0, '0);
		// sizes below two clamp to two: flat top heights give the flat 2x2 normals
		add_step(1'b1, 32'd1, 32'd0, 8'hFF, 2'd0, '0, '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'hFF, 2'd0, '0, '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'hFF, 2'd1,
			mk_normal(0, 0, 0, NY_NEG10, 0, 1'b1), '0, '0);
		add_step(1'b0, 32'd0, 32'd0, 8'hFF, 2'd3,
			mk_normal(1, 0, 0, NY_POS10, 0, 1'b0),
			mk_normal(0, 1, 0, NY_NEG10, 0, 1'b0),
			mk_normal(1, 1, 0, NY_NEG10, 0, 1'b1));

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both sizes come out of reset at 512
		check_register(WIDTH_ADDR, CFG_DIM_RESET);
		check_register(HEIGHT_ADDR, CFG_DIM_RESET);

		foreach (directed_steps[i]) begin
			st = directed_steps[i];
			if (st.retune) begin
				settle_block();
				program_grid(st.w_val, st.h_val);
			end
			feed_sample(st.sample, st.typed, st.t0, st.t1, st.t2);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle_block();
			program_grid(phase_w[ph], phase_h[ph]);
			steady_feed = ($urandom_range(0, 3) == 0);
			for (k = 0; k < phase_items[ph]; k++) begin
				// receiver holds off for a long stretch while samples keep coming,
				// so the output queue fills and full pushes back
				if (ph == 2 && k == 8)
					hold_asks++;
				// and once the sender stops until everything has drained
				if (ph == 2 && k == 40)
					settle_block();
				case ($urandom_range(0, 7))
					0: s = '0;
					1: s = '1;
					default: s = HEIGHT_W'($urandom);
				endcase
				feed_sample(s, 2'd0, '0, '0, '0);
			end
		end

		settle_block();
		$display("%0d height samples over %0d grid settings, widths and heights 2 to 1024",
			samples_sent, grids_programmed);
		$display("%0d normals checked, input held off by full on %0d cycles",
			normals_checked, full_hits);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/hns_pkg.sv
rtl/hns_ram.sv
rtl/hns_front.sv
rtl/hns_queue.sv
rtl/hns_back.sv
rtl/heightmap_normal_stream.sv
bench/heightmap_normal_stream_test.sv
